FILE: sv/tam_pkg.sv
package tam_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 12;
   localparam int SCALE = 10;
   localparam int TEMP_W = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int EVENT_W = 32;

   localparam int TEMP_MAX = 32767;
   localparam int TEMP_MIN = -32768;

   localparam logic signed [TEMP_W-1:0] CAL_OFFSET_RESET = 16'sd0;
   localparam logic signed [TEMP_W-1:0] WARN_LO_RESET = -16'sd200;
   localparam logic signed [TEMP_W-1:0] WARN_HI_RESET = 16'sd1250;
   localparam logic [7:0] HYST_RESET = 8'd20;
   localparam logic signed [TEMP_W-1:0] VALID_MIN_RESET = -16'sd400;
   localparam logic signed [TEMP_W-1:0] VALID_MAX_RESET = 16'sd1500;

   typedef enum logic [2:0] {
      TS_NORMAL    = 3'd0,
      TS_WARN_LOW  = 3'd1,
      TS_WARN_HIGH = 3'd2,
      TS_ERR_LOW   = 3'd3,
      TS_ERR_HIGH  = 3'd4
   } temp_state_type;

   typedef enum logic [1:0] {
      SC_OK        = 2'd0,
      SC_WARN_LOW  = 2'd1,
      SC_WARN_HIGH = 2'd2,
      SC_ERROR     = 2'd3
   } sys_cond_type;

   typedef enum logic [2:0] {
      REG_CAL_OFFSET = 3'd0,
      REG_WARN_LO    = 3'd1,
      REG_WARN_HI    = 3'd2,
      REG_HYST       = 3'd3,
      REG_VALID_MIN  = 3'd4,
      REG_VALID_MAX  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] cal_offset;
      logic signed [TEMP_W-1:0] warn_lo;
      logic signed [TEMP_W-1:0] warn_hi;
      logic [7:0]               hyst_margin;
      logic signed [TEMP_W-1:0] valid_min;
      logic signed [TEMP_W-1:0] valid_max;
   } cfg_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      temp_state_type           temp_state;
      logic                     low_alert_active;
      logic                     high_alert_active;
      logic                     event_valid;
      temp_state_type           event_kind;
      logic [EVENT_W-1:0]       event_number;
      sys_cond_type             system_condition;
      logic                     state_changed;
   } rsp_word_type;

endpackage

FILE: sv/tam_channels.sv
interface tam_req_if import tam_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink (input valid, input adc_sample, output ready);
endinterface

interface tam_rsp_if import tam_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature;
   temp_state_type           temp_state;
   logic                     low_alert_active;
   logic                     high_alert_active;
   logic                     event_valid;
   temp_state_type           event_kind;
   logic [EVENT_W-1:0]       event_number;
   sys_cond_type             system_condition;
   logic                     state_changed;

   modport source (
      output valid, input ready,
      output temperature, output temp_state, output low_alert_active,
      output high_alert_active, output event_valid, output event_kind,
      output event_number, output system_condition, output state_changed
   );
   modport sink (
      input valid, output ready,
      input temperature, input temp_state, input low_alert_active,
      input high_alert_active, input event_valid, input event_kind,
      input event_number, input system_condition, input state_changed
   );
endinterface

FILE: sv/tam_csr.sv
module tam_csr import tam_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index = csr_index_type'(paddr[4:2]);
   assign wr_en = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_CAL_OFFSET: cfg_in.cal_offset = pwdata[TEMP_W-1:0];
            REG_WARN_LO:    cfg_in.warn_lo = pwdata[TEMP_W-1:0];
            REG_WARN_HI:    cfg_in.warn_hi = pwdata[TEMP_W-1:0];
            REG_HYST:       cfg_in.hyst_margin = pwdata[7:0];
            REG_VALID_MIN:  cfg_in.valid_min = pwdata[TEMP_W-1:0];
            REG_VALID_MAX:  cfg_in.valid_max = pwdata[TEMP_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_CAL_OFFSET: prdata = CSR_DATA_W'($signed(cfg_ff.cal_offset));
         REG_WARN_LO:    prdata = CSR_DATA_W'($signed(cfg_ff.warn_lo));
         REG_WARN_HI:    prdata = CSR_DATA_W'($signed(cfg_ff.warn_hi));
         REG_HYST:       prdata = CSR_DATA_W'(cfg_ff.hyst_margin);
         REG_VALID_MIN:  prdata = CSR_DATA_W'($signed(cfg_ff.valid_min));
         REG_VALID_MAX:  prdata = CSR_DATA_W'($signed(cfg_ff.valid_max));
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cal_offset <= CAL_OFFSET_RESET;
         cfg_ff.warn_lo <= WARN_LO_RESET;
         cfg_ff.warn_hi <= WARN_HI_RESET;
         cfg_ff.hyst_margin <= HYST_RESET;
         cfg_ff.valid_min <= VALID_MIN_RESET;
         cfg_ff.valid_max <= VALID_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: sv/tam_core.sv
module tam_core import tam_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [SAMPLE_BITS-1:0] in_sample,
   output logic                   out_valid,
   input  logic                   out_ready,
   output rsp_word_type           out_word
);

   localparam int PROD_W = SAMPLE_BITS + 4;
   localparam int SUM_W = ((PROD_W > TEMP_W) ? PROD_W : TEMP_W) + 2;
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(TEMP_MAX);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(TEMP_MIN);

   logic                   s1_valid_ff, s1_valid_in;
   logic [SAMPLE_BITS-1:0] s1_sample_ff, s1_sample_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_word_type           out_word_ff, out_word_in;

   temp_state_type     status_ff, status_in;
   logic               low_flag_ff, low_flag_in;
   logic               high_flag_ff, high_flag_in;
   logic [EVENT_W-1:0] counter_ff, counter_in;
   sys_cond_type       sys_ff, sys_in;

   logic                     advance;
   logic [PROD_W-1:0]        scaled;
   logic signed [SUM_W-1:0]  sum_full;
   logic signed [TEMP_W-1:0] temp;
   logic signed [TEMP_W:0]   temp_ext;
   logic signed [TEMP_W:0]   low_clear_lim;
   logic signed [TEMP_W:0]   high_clear_lim;
   logic                     ev;
   temp_state_type           kind;

   assign advance = s1_valid_ff && (!out_valid_ff || out_ready);
   assign in_ready = !s1_valid_ff || advance;
   assign out_valid = out_valid_ff;
   assign out_word = out_word_ff;

   always_comb begin
      s1_valid_in = in_ready ? in_valid : s1_valid_ff;
      s1_sample_in = (in_valid && in_ready) ? in_sample : s1_sample_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // scale, offset and saturate; hysteresis clear limits
   always_comb begin
      scaled = PROD_W'(s1_sample_ff) * PROD_W'(SCALE);
      sum_full = $signed(SUM_W'(scaled)) + SUM_W'($signed(cfg.cal_offset));
      if (sum_full > SAT_HI) begin
         temp = TEMP_W'(TEMP_MAX);
      end else if (sum_full < SAT_LO) begin
         temp = TEMP_W'(TEMP_MIN);
      end else begin
         temp = sum_full[TEMP_W-1:0];
      end
      temp_ext = {temp[TEMP_W-1], temp};
      low_clear_lim = $signed({cfg.warn_lo[TEMP_W-1], cfg.warn_lo})
         + $signed({1'b0, 8'd0, cfg.hyst_margin});
      high_clear_lim = $signed({cfg.warn_hi[TEMP_W-1], cfg.warn_hi})
         - $signed({1'b0, 8'd0, cfg.hyst_margin});
   end

   // classification and alert state
   always_comb begin
      status_in = status_ff;
      low_flag_in = low_flag_ff;
      high_flag_in = high_flag_ff;
      sys_in = sys_ff;
      ev = 1'b0;
      kind = TS_NORMAL;
      if (temp < $signed(cfg.valid_min) || temp > $signed(cfg.valid_max)) begin
         status_in = (temp < $signed(cfg.valid_min)) ? TS_ERR_LOW : TS_ERR_HIGH;
         if (sys_ff != SC_ERROR) begin
            sys_in = SC_ERROR;
            ev = 1'b1;
            kind = status_in;
         end
      end else if (temp < $signed(cfg.warn_lo)) begin
         status_in = TS_WARN_LOW;
         if (!low_flag_ff) begin
            low_flag_in = 1'b1;
            high_flag_in = 1'b0;
            sys_in = SC_WARN_LOW;
            ev = 1'b1;
            kind = TS_WARN_LOW;
         end
      end else if (temp > $signed(cfg.warn_hi)) begin
         status_in = TS_WARN_HIGH;
         if (!high_flag_ff) begin
            high_flag_in = 1'b1;
            low_flag_in = 1'b0;
            sys_in = SC_WARN_HIGH;
            ev = 1'b1;
            kind = TS_WARN_HIGH;
         end
      end else begin
         status_in = TS_NORMAL;
         if (low_flag_ff && temp_ext > low_clear_lim) begin
            low_flag_in = 1'b0;
            if (sys_ff == SC_WARN_LOW) begin
               sys_in = SC_OK;
            end
            ev = 1'b1;
         end
         if (high_flag_ff && temp_ext < high_clear_lim) begin
            high_flag_in = 1'b0;
            if (sys_ff == SC_WARN_HIGH) begin
               sys_in = SC_OK;
            end
            ev = 1'b1;
         end
      end

      counter_in = counter_ff + EVENT_W'(ev);

      out_word_in.temperature = temp;
      out_word_in.temp_state = status_in;
      out_word_in.low_alert_active = low_flag_in;
      out_word_in.high_alert_active = high_flag_in;
      out_word_in.event_valid = ev;
      out_word_in.event_kind = kind;
      out_word_in.event_number = ev ? counter_ff : '0;
      out_word_in.system_condition = sys_in;
      out_word_in.state_changed = (status_in != status_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         status_ff <= TS_NORMAL;
         low_flag_ff <= 1'b0;
         high_flag_ff <= 1'b0;
         counter_ff <= '0;
         sys_ff <= SC_OK;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            status_ff <= status_in;
            low_flag_ff <= low_flag_in;
            high_flag_ff <= high_flag_in;
            counter_ff <= counter_in;
            sys_ff <= sys_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_sample_ff <= s1_sample_in;
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

endmodule

FILE: sv/temperature_alert_monitor_unit.sv
// temperature alert monitor
// req channel carries one adc_sample word; rsp channel returns one result word
// per sample: saturated temperature in tenths of a degree, band state, latched
// low/high alert flags, an optional numbered event and the system condition.
// thresholds, hysteresis margin, calibration offset and valid range sit in
// six apb registers at byte addresses 0x00..0x14; write them only while idle.
// rsp valid follows the req accept through the input register, then the
// result register after one pass of compare logic.
// throughput: one word per cycle while rsp is not stalled; alert state feeds back within that pass.
// rsp stalls: the result register holds its word and the input register can still
// take one sample, so req.ready drops only once both registers are full.
// reset (synchronous) clears flags, event counter and system condition,
// empties both registers and loads the register reset values.
module temperature_alert_monitor_unit import tam_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   tam_req_if.sink               req,
   tam_rsp_if.source             rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type      cfg;
   rsp_word_type word;

   tam_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tam_core #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_sample (req.adc_sample),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_word  (word)
   );

   assign rsp.temperature = word.temperature;
   assign rsp.temp_state = word.temp_state;
   assign rsp.low_alert_active = word.low_alert_active;
   assign rsp.high_alert_active = word.high_alert_active;
   assign rsp.event_valid = word.event_valid;
   assign rsp.event_kind = word.event_kind;
   assign rsp.event_number = word.event_number;
   assign rsp.system_condition = word.system_condition;
   assign rsp.state_changed = word.state_changed;

endmodule

FILE: sv/tam_checker.sv
module tam_checker import tam_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [TEMP_W-1:0] temperature,
   input temp_state_type           temp_state,
   input logic                     low_alert_active,
   input logic                     high_alert_active,
   input logic                     event_valid,
   input temp_state_type           event_kind,
   input logic [EVENT_W-1:0]       event_number,
   input sys_cond_type             system_condition
);

   // stalled word holds its temperature and event number
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(temperature)
         && $stable(event_number))
   else $error("rsp word changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !event_valid |-> event_kind == TS_NORMAL && event_number == '0)
   else $error("event fields set without event");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(low_alert_active && high_alert_active))
   else $error("both alert flags set");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (temp_state == TS_ERR_LOW || temp_state == TS_ERR_HIGH)
         |-> system_condition == SC_ERROR)
   else $error("error band without error condition");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && temp_state == TS_WARN_LOW |-> low_alert_active)
   else $error("warn low without low alert flag");

endmodule

bind temperature_alert_monitor_unit tam_checker u_tam_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .temperature       (rsp.temperature),
   .temp_state        (rsp.temp_state),
   .low_alert_active  (rsp.low_alert_active),
   .high_alert_active (rsp.high_alert_active),
   .event_valid       (rsp.event_valid),
   .event_kind        (rsp.event_kind),
   .event_number      (rsp.event_number),
   .system_condition  (rsp.system_condition)
);

FILE: verif/temperature_alert_monitor_unit_tb.sv
`timescale 1ns / 100ps

module temperature_alert_monitor_unit_tb;
   import tam_pkg::*;

   localparam int HOLD_OFF_CYCLES = 80;
   localparam int RANDOM_PHASES = 10;
   localparam int WORDS_PER_PHASE = 125;
   localparam int ADC_FULL_SCALE = (1 << SAMPLE_BITS_DEFAULT) - 1;
   localparam logic [2:0] REG_SPARE = 3'd6;

   typedef enum {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_pattern_type;

   typedef struct {
      bit                       is_write;
      logic [2:0]               reg_idx;
      int                       value;
      logic [SAMPLE_BITS_DEFAULT-1:0] sample;
      bit                       pinned;
      int                       exp_temp;
      temp_state_type           exp_band;
   } step_row_type;

   typedef struct {
      bit                       known;
      logic signed [TEMP_W-1:0] temp;
      temp_state_type           band;
   } hand_reading_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   tam_req_if req_ch ();
   tam_rsp_if rsp_ch ();

   temperature_alert_monitor_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predictor copy of the registers and alarm state
   int cfg_offset = CAL_OFFSET_RESET;
   int cfg_low = WARN_LO_RESET;
   int cfg_high = WARN_HI_RESET;
   int cfg_hyst = HYST_RESET;
   int cfg_min = VALID_MIN_RESET;
   int cfg_max = VALID_MAX_RESET;

   temp_state_type model_band = TS_NORMAL;
   sys_cond_type model_condition = SC_OK;
   bit model_low_alarm = 1'b0;
   bit model_high_alarm = 1'b0;
   logic [EVENT_W-1:0] model_events = '0;

   rsp_word_type expected_readings[$];
   hand_reading_type hand_readings[$];
   step_row_type directed_steps[$];

   int mismatch_count = 0;
   int burst_left = 0;
   bit hold_off_request = 1'b0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t ns mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
   endtask

   function automatic void set_model_register(input logic [2:0] idx, input int value);
      logic [31:0] bits;
      bits = 32'(value);
      case (csr_index_type'(idx))
         REG_CAL_OFFSET: cfg_offset = int'($signed(bits[15:0]));
         REG_WARN_LO:    cfg_low = int'($signed(bits[15:0]));
         REG_WARN_HI:    cfg_high = int'($signed(bits[15:0]));
         REG_HYST:       cfg_hyst = int'(bits[7:0]);
         REG_VALID_MIN:  cfg_min = int'($signed(bits[15:0]));
         REG_VALID_MAX:  cfg_max = int'($signed(bits[15:0]));
         default: ;
      endcase
   endfunction

   function automatic rsp_word_type predict_reading(input logic [SAMPLE_BITS_DEFAULT-1:0] sample);
      rsp_word_type w;
      int t;
      temp_state_type band;
      temp_state_type kind;
      bit fired;
      t = int'(sample) * SCALE + cfg_offset;
      if (t > TEMP_MAX) t = TEMP_MAX;
      if (t < TEMP_MIN) t = TEMP_MIN;
      fired = 1'b0;
      kind = TS_NORMAL;
      if (t < cfg_min || t > cfg_max) begin
         band = (t < cfg_min) ? TS_ERR_LOW : TS_ERR_HIGH;
         if (model_condition != SC_ERROR) begin
            model_condition = SC_ERROR;
            fired = 1'b1;
            kind = band;
         end
      end else if (t < cfg_low) begin
         band = TS_WARN_LOW;
         if (!model_low_alarm) begin
            model_low_alarm = 1'b1;
            model_high_alarm = 1'b0;
            model_condition = SC_WARN_LOW;
            fired = 1'b1;
            kind = TS_WARN_LOW;
         end
      end else if (t > cfg_high) begin
         band = TS_WARN_HIGH;
         if (!model_high_alarm) begin
            model_high_alarm = 1'b1;
            model_low_alarm = 1'b0;
            model_condition = SC_WARN_HIGH;
            fired = 1'b1;
            kind = TS_WARN_HIGH;
         end
      end else begin
         band = TS_NORMAL;
         if (model_low_alarm && t > cfg_low + cfg_hyst) begin
            model_low_alarm = 1'b0;
            if (model_condition == SC_WARN_LOW) model_condition = SC_OK;
            fired = 1'b1;
         end
         if (model_high_alarm && t < cfg_high - cfg_hyst) begin
            model_high_alarm = 1'b0;
            if (model_condition == SC_WARN_HIGH) model_condition = SC_OK;
            fired = 1'b1;
         end
      end
      w.temperature = t[15:0];
      w.temp_state = band;
      w.low_alert_active = model_low_alarm;
      w.high_alert_active = model_high_alarm;
      w.event_valid = fired;
      w.event_kind = kind;
      w.event_number = fired ? model_events : '0;
      w.system_condition = model_condition;
      w.state_changed = (band != model_band);
      if (fired) model_events = model_events + 1'b1;
      model_band = band;
      return w;
   endfunction

   // random word aimed mostly at the band edges of the current setting
   function automatic logic [SAMPLE_BITS_DEFAULT-1:0] pick_sample();
      int target;
      int raw;
      if ($urandom_range(0, 9) < 3) return $urandom_range(0, ADC_FULL_SCALE);
      case ($urandom_range(0, 5))
         0: target = cfg_min;
         1: target = cfg_max;
         2: target = cfg_low;
         3: target = cfg_high;
         4: target = cfg_low + cfg_hyst;
         default: target = cfg_high - cfg_hyst;
      endcase
      target = target + int'($urandom_range(0, 40)) - 20;
      raw = target - cfg_offset;
      if (raw < 0) return '0;
      raw = raw / SCALE;
      if (raw > ADC_FULL_SCALE) raw = ADC_FULL_SCALE;
      return raw[SAMPLE_BITS_DEFAULT-1:0];
   endfunction

   function automatic int pick_register_value();
      case ($urandom_range(0, 7))
         0: return TEMP_MIN;
         1: return TEMP_MAX;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   function automatic step_row_type cfg_row(input logic [2:0] idx, input int value);
      step_row_type r;
      r = '{1'b1, idx, value, '0, 1'b0, 0, TS_NORMAL};
      return r;
   endfunction

   function automatic step_row_type sample_row(input logic [SAMPLE_BITS_DEFAULT-1:0] s,
                                               input bit pinned, input int t,
                                               input temp_state_type band);
      step_row_type r;
      r = '{1'b0, REG_SPARE, 0, s, pinned, t, band};
      return r;
   endfunction

   task automatic write_register(input logic [2:0] idx, input int value);
      logic [31:0] readback;
      logic [31:0] field_mask;
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      set_model_register(idx, value);
      @(negedge clock);
      if (idx > REG_VALID_MAX) begin
         psel <= 1'b0;
         penable <= 1'b0;
         pwrite <= 1'b0;
      end else begin
         pwrite <= 1'b0;
         penable <= 1'b0;
         @(negedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
         readback = prdata;
         @(negedge clock);
         psel <= 1'b0;
         penable <= 1'b0;
         field_mask = (idx == REG_HYST) ? 32'h0000_00ff : 32'h0000_ffff;
         if ((readback & field_mask) != (32'(value) & field_mask)) begin
            report_mismatch("register readback", readback, 32'(value));
         end
      end
   endtask

   task automatic send_sample(input logic [SAMPLE_BITS_DEFAULT-1:0] s, input bit pinned,
                              input int t, input temp_state_type band);
      int gap;
      hand_reading_type h;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      h.known = pinned;
      h.temp = t[15:0];
      h.band = band;
      hand_readings.push_back(h);
      req_ch.valid <= 1'b1;
      req_ch.adc_sample <= s;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_readings.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

   // receiver: changing stall pattern, plus a long hold-off on request
   initial begin
      rx_pattern_type pattern;
      int rx_cycle;
      pattern = RX_ALWAYS;
      rx_cycle = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            if (rx_cycle % 64 == 0) pattern = rx_pattern_type'($urandom_range(0, 3));
            rx_cycle++;
            case (pattern)
               RX_ALWAYS:   rsp_ch.ready <= 1'b1;
               RX_MOSTLY:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               RX_SPARSE:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default:     rsp_ch.ready <= (rx_cycle % 5 != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      hand_reading_type h;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.temperature = rsp_ch.temperature;
            got.temp_state = rsp_ch.temp_state;
            got.low_alert_active = rsp_ch.low_alert_active;
            got.high_alert_active = rsp_ch.high_alert_active;
            got.event_valid = rsp_ch.event_valid;
            got.event_kind = rsp_ch.event_kind;
            got.event_number = rsp_ch.event_number;
            got.system_condition = rsp_ch.system_condition;
            got.state_changed = rsp_ch.state_changed;
            if (expected_readings.size() == 0) begin
               report_mismatch("unexpected word, temperature", 32'(got.temperature), '0);
            end else begin
               want = expected_readings.pop_front();
               if (got.temperature !== want.temperature)
                  report_mismatch("temperature", 32'(got.temperature), 32'(want.temperature));
               if (got.temp_state !== want.temp_state)
                  report_mismatch("temp_state", 32'(got.temp_state), 32'(want.temp_state));
               if (got.low_alert_active !== want.low_alert_active)
                  report_mismatch("low_alert_active", 32'(got.low_alert_active),
                                  32'(want.low_alert_active));
               if (got.high_alert_active !== want.high_alert_active)
                  report_mismatch("high_alert_active", 32'(got.high_alert_active),
                                  32'(want.high_alert_active));
               if (got.event_valid !== want.event_valid)
                  report_mismatch("event_valid", 32'(got.event_valid), 32'(want.event_valid));
               if (got.event_kind !== want.event_kind)
                  report_mismatch("event_kind", 32'(got.event_kind), 32'(want.event_kind));
               if (got.event_number !== want.event_number)
                  report_mismatch("event_number", got.event_number, want.event_number);
               if (got.system_condition !== want.system_condition)
                  report_mismatch("system_condition", 32'(got.system_condition),
                                  32'(want.system_condition));
               if (got.state_changed !== want.state_changed)
                  report_mismatch("state_changed", 32'(got.state_changed),
                                  32'(want.state_changed));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            h = hand_readings.pop_front();
            want = predict_reading(req_ch.adc_sample);
            if (h.known) begin
               want.temperature = h.temp;
               want.temp_state = h.band;
            end
            expected_readings.push_back(want);
         end
      end
   end

   initial begin
      int mode;
      int lo;
      int hi;
      int swap_tmp;
      int v_off;
      int v_low;
      int v_high;
      int v_hyst;
      int v_min;
      int v_max;
      int edges[$];
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.adc_sample = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;

      // reset settings: high side, hysteresis, error lockout
      directed_steps.push_back(sample_row(0, 1, 0, TS_NORMAL));
      directed_steps.push_back(sample_row(126, 1, 1260, TS_WARN_HIGH));
      directed_steps.push_back(sample_row(125, 1, 1250, TS_NORMAL));
      directed_steps.push_back(sample_row(123, 1, 1230, TS_NORMAL));
      directed_steps.push_back(sample_row(122, 1, 1220, TS_NORMAL));
      directed_steps.push_back(sample_row(151, 1, 1510, TS_ERR_HIGH));
      directed_steps.push_back(sample_row(ADC_FULL_SCALE, 1, TEMP_MAX, TS_ERR_HIGH));
      directed_steps.push_back(sample_row(130, 1, 1300, TS_WARN_HIGH));
      directed_steps.push_back(sample_row(140, 1, 1400, TS_WARN_HIGH));
      directed_steps.push_back(sample_row(151, 1, 1510, TS_ERR_HIGH));
      directed_steps.push_back(sample_row(130, 1, 1300, TS_WARN_HIGH));
      directed_steps.push_back(sample_row(100, 1, 1000, TS_NORMAL));
      // most negative offset, full valid range, widest margin
      directed_steps.push_back(cfg_row(REG_CAL_OFFSET, TEMP_MIN));
      directed_steps.push_back(cfg_row(REG_VALID_MIN, TEMP_MIN));
      directed_steps.push_back(cfg_row(REG_VALID_MAX, TEMP_MAX));
      directed_steps.push_back(cfg_row(REG_WARN_LO, -1000));
      directed_steps.push_back(cfg_row(REG_WARN_HI, 1000));
      directed_steps.push_back(cfg_row(REG_HYST, 255));
      directed_steps.push_back(cfg_row(REG_SPARE, 12345));
      directed_steps.push_back(sample_row(0, 1, TEMP_MIN, TS_WARN_LOW));
      directed_steps.push_back(sample_row(3177, 0, 0, TS_NORMAL));
      directed_steps.push_back(sample_row(3250, 0, 0, TS_NORMAL));
      directed_steps.push_back(sample_row(ADC_FULL_SCALE, 0, 0, TS_NORMAL));
      directed_steps.push_back(sample_row(0, 1, TEMP_MIN, TS_WARN_LOW));
      // saturation at the top, zero margin
      directed_steps.push_back(cfg_row(REG_CAL_OFFSET, TEMP_MAX));
      directed_steps.push_back(cfg_row(REG_WARN_HI, TEMP_MAX - 1));
      directed_steps.push_back(cfg_row(REG_HYST, 0));
      directed_steps.push_back(sample_row(1, 1, TEMP_MAX, TS_WARN_HIGH));
      directed_steps.push_back(sample_row(ADC_FULL_SCALE, 1, TEMP_MAX, TS_WARN_HIGH));
      directed_steps.push_back(cfg_row(REG_VALID_MAX, TEMP_MAX - 1));
      directed_steps.push_back(sample_row(ADC_FULL_SCALE, 1, TEMP_MAX, TS_ERR_HIGH));
      // crossed thresholds, then error low
      directed_steps.push_back(cfg_row(REG_CAL_OFFSET, 0));
      directed_steps.push_back(cfg_row(REG_VALID_MIN, -400));
      directed_steps.push_back(cfg_row(REG_VALID_MAX, 1500));
      directed_steps.push_back(cfg_row(REG_WARN_LO, 500));
      directed_steps.push_back(cfg_row(REG_WARN_HI, 300));
      directed_steps.push_back(sample_row(40, 1, 400, TS_WARN_LOW));
      directed_steps.push_back(sample_row(60, 1, 600, TS_WARN_HIGH));
      directed_steps.push_back(sample_row(0, 1, 0, TS_WARN_LOW));
      directed_steps.push_back(cfg_row(REG_CAL_OFFSET, TEMP_MIN));
      directed_steps.push_back(sample_row(0, 1, TEMP_MIN, TS_ERR_LOW));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_write) begin
            wait_idle();
            write_register(directed_steps[i].reg_idx, directed_steps[i].value);
         end else begin
            send_sample(directed_steps[i].sample, directed_steps[i].pinned,
                        directed_steps[i].exp_temp, directed_steps[i].exp_band);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         mode = $urandom_range(0, 9);
         v_hyst = $urandom_range(0, 255);
         if (mode == 7 || mode == 8) begin
            v_off = pick_register_value();
            v_low = pick_register_value();
            v_high = pick_register_value();
            v_min = pick_register_value();
            v_max = pick_register_value();
         end else begin
            v_off = int'($urandom_range(0, 65534)) - 32768;
            lo = v_off;
            hi = v_off + ADC_FULL_SCALE * SCALE;
            if (hi > TEMP_MAX) hi = TEMP_MAX;
            edges.delete();
            repeat (4) edges.push_back(lo + int'($urandom_range(0, hi - lo)));
            edges.sort();
            v_min = edges[0];
            v_low = edges[1];
            v_high = edges[2];
            v_max = edges[3];
            if (mode == 9) begin
               swap_tmp = v_low;
               v_low = v_high;
               v_high = swap_tmp;
            end
         end
         write_register(REG_CAL_OFFSET, v_off);
         write_register(REG_WARN_LO, v_low);
         write_register(REG_WARN_HI, v_high);
         write_register(REG_HYST, v_hyst);
         write_register(REG_VALID_MIN, v_min);
         write_register(REG_VALID_MAX, v_max);
         if ($urandom_range(0, 3) == 0) write_register(REG_SPARE, pick_register_value());
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if ((phase == 2 && n == 40) || (phase == 6 && n == 60)) hold_off_request = 1'b1;
            send_sample(pick_sample(), 1'b0, 0, TS_NORMAL);
         end
      end

      wait_idle();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
